// File: rtl/core/bblru_pkg.sv
// Shared types and constants of the size-aware LRU cache policy block.
package bblru_pkg;

  localparam int ENTRIES  = 16;
  localparam int SLOT_W   = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int KEY_BITS = 32;
  localparam int MB_SHIFT = 20;
  localparam int BYTES_W  = 33;
  localparam int CAPMB_W  = 13;
  localparam int PADDR_W  = 2;

  localparam logic [CAPMB_W-1:0] CAP_MIN_MB = 13'd1024;
  localparam logic [CAPMB_W-1:0] CAP_MAX_MB = 13'd4096;

  localparam logic [PADDR_W-1:0] REG_CAPACITY = 2'd0;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_EVICT  = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] key_id;
    logic [31:0] size_bytes;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic               hit;
    logic [31:0]        hit_size;
    logic [31:0]        evicted_key;
    logic [BYTES_W-1:0] total_bytes;
    logic [31:0]        hits_seen;
    logic [31:0]        misses_seen;
    logic               last;
  } out_item_t;

  // Front-end queue head as seen by the back end.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } fq_head_t;

endpackage

// File: rtl/core/bblru_front.sv
// Front end: accepts commands, drops unused codes and queues the rest.
module bblru_front import bblru_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item,
  output fq_head_t head,
  input  logic     head_pop
);

  logic [1:0] cnt_r;
  logic       wp_r, rp_r;
  in_item_t   mem_r [2];
  logic       wr_en, rd_en;

  // A transaction with the unused command code is taken but not stored.
  assign full  = (cnt_r == 2'd2);
  assign wr_en = push && !full && (in_item.command != CMD_NONE);
  assign rd_en = head_pop && (cnt_r != 2'd0);

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = mem_r[rp_r];

  // Two-entry queue between front and back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        wp_r <= !wp_r;
      end
      if (rd_en) begin
        rp_r <= !rp_r;
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= in_item;
    end
  end

endmodule

// File: rtl/core/bblru_back.sv
// Back end: tag table, LRU ranks, byte total, counters and the result queue.
module bblru_back import bblru_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  fq_head_t           head,
  output logic               head_pop,
  input  logic [BYTES_W-1:0] cap_bytes,
  output logic               empty,
  input  logic               pop,
  output out_item_t          out_item
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_CHECK = 2'd2;

  logic [1:0]          state_r;
  in_item_t            cur_r;
  logic                emitted_r;
  logic                pend_r;
  logic [KEY_BITS-1:0] pend_key_r;
  logic [BYTES_W-1:0]  pend_bytes_r;

  logic [KEY_BITS-1:0] key_r   [ENTRIES];
  logic [31:0]         size_r  [ENTRIES];
  logic [SLOT_W-1:0]   rank_r  [ENTRIES];
  logic [ENTRIES-1:0]  valid_r;
  logic [BYTES_W-1:0]  bytes_r;
  logic [31:0]         hits_r, miss_r;

  out_item_t           oq_r [2];
  logic [1:0]          oq_cnt_r;
  logic                oq_wp_r, oq_rp_r;

  logic [ENTRIES-1:0]  match, oldest;
  logic                hit_any;
  logic [SLOT_W-1:0]   match_idx, old_idx, free_idx;
  logic [CNT_W-1:0]    nvalid;
  logic                space, over;
  logic [31:0]         hits_inc, miss_inc;
  logic [BYTES_W-1:0]  evict_bytes, replace_bytes, append_bytes;
  logic                evict_last;
  logic                emit_en;
  out_item_t           emit_item;
  logic                oq_rd;

  // Parallel tag compare, oldest-entry search and free-slot search.
  always_comb begin
    match_idx = '0;
    old_idx   = '0;
    free_idx  = '0;
    nvalid    = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      match[i]  = valid_r[i] && (key_r[i] == cur_r.key_id[KEY_BITS-1:0]);
      oldest[i] = valid_r[i] && (rank_r[i] == '0);
      if (match[i]) begin
        match_idx = SLOT_W'(i);
      end
      if (oldest[i]) begin
        old_idx = SLOT_W'(i);
      end
      if (!valid_r[i]) begin
        free_idx = SLOT_W'(i);
      end
      nvalid = nvalid + CNT_W'(valid_r[i]);
    end
    hit_any = |match;
  end

  assign space    = (oq_cnt_r != 2'd2);
  assign over     = (bytes_r > cap_bytes) && (nvalid != '0);
  assign hits_inc = (hits_r == '1) ? hits_r : hits_r + 32'd1;
  assign miss_inc = (miss_r == '1) ? miss_r : miss_r + 32'd1;

  assign evict_bytes   = bytes_r - {1'b0, size_r[old_idx]};
  assign replace_bytes = bytes_r - {1'b0, size_r[match_idx]} + {1'b0, cur_r.size_bytes};
  assign append_bytes  = bytes_r + {1'b0, cur_r.size_bytes};
  assign evict_last    = !(evict_bytes > cap_bytes) || (nvalid == CNT_W'(1));

  assign head_pop = (state_r == ST_IDLE) && head.valid;

  // Result built this cycle, if any.
  always_comb begin
    emit_en   = 1'b0;
    emit_item = '0;
    emit_item.total_bytes = bytes_r;
    emit_item.hits_seen   = hits_r;
    emit_item.misses_seen = miss_r;
    unique case (state_r)
      ST_EXEC: begin
        if (cur_r.command == CMD_LOOKUP) begin
          emit_en              = 1'b1;
          emit_item.result_kind = KIND_LOOKUP;
          emit_item.last       = 1'b1;
          if (hit_any) begin
            emit_item.hit       = 1'b1;
            emit_item.hit_size  = size_r[match_idx];
            emit_item.hits_seen = hits_inc;
          end else begin
            emit_item.misses_seen = miss_inc;
          end
        end else if (cur_r.command == CMD_CLEAR) begin
          emit_en               = 1'b1;
          emit_item.result_kind = KIND_CLEAR;
          emit_item.total_bytes = '0;
          emit_item.hits_seen   = '0;
          emit_item.misses_seen = '0;
          emit_item.last        = 1'b1;
        end
      end
      ST_CHECK: begin
        if (pend_r) begin
          emit_en               = 1'b1;
          emit_item.result_kind = KIND_EVICT;
          emit_item.evicted_key = 32'(pend_key_r);
          emit_item.total_bytes = pend_bytes_r;
          emit_item.last        = !over;
        end else if (over) begin
          emit_en               = 1'b1;
          emit_item.result_kind = KIND_EVICT;
          emit_item.evicted_key = 32'(key_r[old_idx]);
          emit_item.total_bytes = evict_bytes;
          emit_item.last        = evict_last;
        end else if (!emitted_r) begin
          emit_en               = 1'b1;
          emit_item.result_kind = KIND_INSERT;
          emit_item.last        = 1'b1;
        end
      end
      default: begin
        emit_en = 1'b0;
      end
    endcase
  end

  // Sequencer and table updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      emitted_r <= 1'b0;
      pend_r    <= 1'b0;
      valid_r   <= '0;
      bytes_r   <= '0;
      hits_r    <= '0;
      miss_r    <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (head.valid) begin
            cur_r     <= head.item;
            emitted_r <= 1'b0;
            pend_r    <= 1'b0;
            state_r   <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (cur_r.command == CMD_LOOKUP) begin
            if (space) begin
              if (hit_any) begin
                hits_r <= hits_inc;
                for (int i = 0; i < ENTRIES; i++) begin
                  if (valid_r[i] && rank_r[i] > rank_r[match_idx]) begin
                    rank_r[i] <= rank_r[i] - SLOT_W'(1);
                  end
                end
                rank_r[match_idx] <= SLOT_W'(nvalid - CNT_W'(1));
              end else begin
                miss_r <= miss_inc;
              end
              state_r <= ST_IDLE;
            end
          end else if (cur_r.command == CMD_CLEAR) begin
            if (space) begin
              valid_r <= '0;
              bytes_r <= '0;
              hits_r  <= '0;
              miss_r  <= '0;
              for (int i = 0; i < ENTRIES; i++) begin
                rank_r[i] <= '0;
              end
              state_r <= ST_IDLE;
            end
          end else if (hit_any) begin
            // Repeated key: swap the size and make the entry newest.
            bytes_r           <= replace_bytes;
            size_r[match_idx] <= cur_r.size_bytes;
            for (int i = 0; i < ENTRIES; i++) begin
              if (valid_r[i] && rank_r[i] > rank_r[match_idx]) begin
                rank_r[i] <= rank_r[i] - SLOT_W'(1);
              end
            end
            rank_r[match_idx] <= SLOT_W'(nvalid - CNT_W'(1));
            state_r           <= ST_CHECK;
          end else if (nvalid == CNT_W'(ENTRIES)) begin
            // Table full: drop the oldest entry and report it later.
            valid_r[old_idx] <= 1'b0;
            bytes_r          <= evict_bytes;
            pend_r           <= 1'b1;
            pend_key_r       <= key_r[old_idx];
            pend_bytes_r     <= evict_bytes;
            for (int i = 0; i < ENTRIES; i++) begin
              if (valid_r[i] && rank_r[i] != '0) begin
                rank_r[i] <= rank_r[i] - SLOT_W'(1);
              end
            end
          end else begin
            valid_r[free_idx] <= 1'b1;
            key_r[free_idx]   <= cur_r.key_id[KEY_BITS-1:0];
            size_r[free_idx]  <= cur_r.size_bytes;
            rank_r[free_idx]  <= SLOT_W'(nvalid);
            bytes_r           <= append_bytes;
            state_r           <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (pend_r) begin
            if (space) begin
              pend_r    <= 1'b0;
              emitted_r <= 1'b1;
              if (!over) begin
                state_r <= ST_IDLE;
              end
            end
          end else if (over) begin
            if (space) begin
              valid_r[old_idx] <= 1'b0;
              bytes_r          <= evict_bytes;
              emitted_r        <= 1'b1;
              for (int i = 0; i < ENTRIES; i++) begin
                if (valid_r[i] && rank_r[i] != '0) begin
                  rank_r[i] <= rank_r[i] - SLOT_W'(1);
                end
              end
              if (evict_last) begin
                state_r <= ST_IDLE;
              end
            end
          end else if (!emitted_r) begin
            if (space) begin
              state_r <= ST_IDLE;
            end
          end else begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Two-entry result queue.
  assign oq_rd    = pop && (oq_cnt_r != 2'd0);
  assign empty    = (oq_cnt_r == 2'd0);
  assign out_item = oq_r[oq_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_cnt_r <= 2'd0;
      oq_wp_r  <= 1'b0;
      oq_rp_r  <= 1'b0;
    end else begin
      if (emit_en && space) begin
        oq_wp_r <= !oq_wp_r;
      end
      if (oq_rd) begin
        oq_rp_r <= !oq_rp_r;
      end
      if (emit_en && space && !oq_rd) begin
        oq_cnt_r <= oq_cnt_r + 2'd1;
      end else if (oq_rd && !(emit_en && space)) begin
        oq_cnt_r <= oq_cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_en && space) begin
      oq_r[oq_wp_r] <= emit_item;
    end
  end

`ifndef ASSERT_OFF
  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r <= 2'd2) else $error("result queue overfilled");
  a_one_oldest: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(oldest)) else $error("more than one oldest entry");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) && (cur_r.command == CMD_CLEAR) && space
    |=> (bytes_r == '0) && (hits_r == '0) && (valid_r == '0))
    else $error("clear left state behind");
  a_pend_state: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == ST_EXEC) || (state_r == ST_CHECK))
    else $error("pending eviction outside an insert");
`endif

endmodule

// File: rtl/core/byte_budget_lru_cache_policy.sv
// Top level: configuration register, front end and back end of the LRU policy.
// A command waits in the front queue and is taken into cur_r in IDLE; a lookup or
// clear result enters the result queue from EXEC, an insert result or eviction from
// CHECK (a full table first loses its oldest entry in EXEC). The single sequencer ends
// each command and its evictions before the next; a full result queue stalls it.
// Reset (synchronous, rst_n low): table empty, byte total, counters zero, 1024 MiB.
module byte_budget_lru_cache_policy import bblru_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  in_item_t           in_item,
  output logic               empty,
  input  logic               pop,
  output out_item_t          out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [CAPMB_W-1:0] cap_mb_r;
  logic [CAPMB_W-1:0] cap_mb_cl;
  logic [BYTES_W-1:0] cap_bytes;
  fq_head_t           head;
  logic               head_pop;

  // Configuration register write and read.
  assign pready = 1'b1;
  assign prdata = (paddr == REG_CAPACITY) ? {{(32-CAPMB_W){1'b0}}, cap_mb_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_mb_r <= CAP_MIN_MB;
    end else if (psel && penable && pwrite && (paddr == REG_CAPACITY)) begin
      cap_mb_r <= pwdata[CAPMB_W-1:0];
    end
  end

  // Clamp the budget and scale mebibytes to bytes.
  always_comb begin
    cap_mb_cl = cap_mb_r;
    if (cap_mb_r < CAP_MIN_MB) begin
      cap_mb_cl = CAP_MIN_MB;
    end else if (cap_mb_r > CAP_MAX_MB) begin
      cap_mb_cl = CAP_MAX_MB;
    end
  end
  assign cap_bytes = {cap_mb_cl, {MB_SHIFT{1'b0}}};

  bblru_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .head     (head),
    .head_pop (head_pop)
  );

  bblru_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .head_pop  (head_pop),
    .cap_bytes (cap_bytes),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule
